// File: src/light_sensor_autorange_ema_macros.svh
// Assertion macros for the light sensor auto-range block.
`ifndef LIGHT_SENSOR_AUTORANGE_EMA_MACROS_SVH
`define LIGHT_SENSOR_AUTORANGE_EMA_MACROS_SVH
`ifndef SYNTHESIS
`define LSAE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define LSAE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define LSAE_ASSERT(lbl, prop, msg)
`define LSAE_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// File: src/lsa_pkg.sv
package lsa_pkg;

  localparam int EMA_FRACTION_BITS = 8;

  localparam int RAW_W      = 16;
  localparam int LUX_W      = 25;
  localparam int PCT_W      = 7;
  localparam int GAIN_W     = 2;
  localparam int INTEG_W    = 3;
  localparam int SHIFT_W    = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int EMA_W = LUX_W + EMA_FRACTION_BITS;
  // 85*ema + 15*lux + 50 stays below 128 * 2^EMA_W
  localparam int SUM_W = EMA_W + 7;
  localparam int X_W   = SUM_W - 2;
  // 2^CHUNK_W is 1 mod 25, so x/25 splits into high and low chunks
  localparam int CHUNK_W = 20;
  localparam int XH_W    = X_W - CHUNK_W;
  localparam int S2_W    = ((XH_W > CHUNK_W) ? XH_W : CHUNK_W) + 1;
  localparam int CHUNK_Q_W = 16;
  localparam logic [CHUNK_Q_W-1:0] CHUNK_Q = CHUNK_Q_W'(((1 << CHUNK_W) - 1) / 25);
  localparam int QH_W = XH_W + CHUNK_Q_W;
  localparam int REC_K = S2_W + 5;
  localparam int REC_M_W = REC_K - 4;
  localparam longint REC_M_L = ((64'sd1 <<< REC_K) + 64'sd24) / 64'sd25;
  localparam logic [REC_M_W-1:0] REC_M = REC_M_W'(REC_M_L);
  localparam int PROD_W = S2_W + REC_M_W;
  localparam int QL_W = PROD_W - REC_K;

  localparam logic [SUM_W-1:0] ROUND_HALF = SUM_W'(50);

  localparam logic [GAIN_W-1:0] GAIN_MIN   = 2'd0;
  localparam logic [GAIN_W-1:0] GAIN_MAX   = 2'd3;
  localparam logic [GAIN_W-1:0] GAIN_RESET = 2'd1;

  localparam logic [INTEG_W-1:0] INTEG_MAX   = 3'd5;
  localparam logic [INTEG_W-1:0] INTEG_RESET = 3'd2;
  localparam logic [RAW_W-1:0]   HIGH_RESET  = 16'd65520;
  localparam logic [RAW_W-1:0]   LOW_RESET   = 16'd100;

  localparam logic [PCT_W-1:0] PCT_MIN = 7'd5;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INTEGRATION    = 2'd0,
    REG_HIGH_THRESHOLD = 2'd1,
    REG_LOW_THRESHOLD  = 2'd2
  } reg_index_t;

  localparam int BRIGHT_STEPS = 95;

  localparam logic [LUX_W-1:0] BRIGHT_ROM [0:BRIGHT_STEPS-1] = '{
    25'd27, 25'd55, 25'd86, 25'd120, 25'd158, 25'd198, 25'd243, 25'd292, 25'd345,
    25'd404, 25'd467, 25'd537, 25'd614, 25'd697, 25'd789, 25'd889, 25'd998,
    25'd1118, 25'd1249, 25'd1392, 25'd1548, 25'd1719, 25'd1907, 25'd2111,
    25'd2336, 25'd2581, 25'd2849, 25'd3142, 25'd3463, 25'd3813, 25'd4197,
    25'd4617, 25'd5076, 25'd5578, 25'd6127, 25'd6728, 25'd7385, 25'd8104,
    25'd8890, 25'd9749, 25'd10690, 25'd11719, 25'd12844, 25'd14074, 25'd15421,
    25'd16893, 25'd18504, 25'd20265, 25'd22192, 25'd24299, 25'd26605,
    25'd29126, 25'd31884, 25'd34901, 25'd38200, 25'd41809, 25'd45757,
    25'd50075, 25'd54797, 25'd59963, 25'd65614, 25'd71794, 25'd78554,
    25'd85948, 25'd94036, 25'd102882, 25'd112558, 25'd123142, 25'd134718,
    25'd147380, 25'd161230, 25'd176378, 25'd192948, 25'd211072, 25'd230896,
    25'd252579, 25'd276296, 25'd302237, 25'd330612, 25'd361649, 25'd395596,
    25'd432727, 25'd473342, 25'd517766, 25'd566356, 25'd619504, 25'd677638,
    25'd741224, 25'd810774, 25'd886848, 25'd970057, 25'd1061071, 25'd1160622,
    25'd1269510, 25'd1388612
  };

  // binary search over the sorted thresholds: number of entries at or below lux
  function automatic logic [PCT_W-1:0] bright_count(input logic [LUX_W-1:0] lux);
    logic [PCT_W-1:0] idx;
    logic [PCT_W:0]   cand;
    idx = '0;
    for (int b = PCT_W - 1; b >= 0; b--) begin
      cand = {1'b0, idx} | ((PCT_W + 1)'(1) << b);
      if (cand <= (PCT_W + 1)'(BRIGHT_STEPS) &&
          lux >= BRIGHT_ROM[PCT_W'(cand - (PCT_W + 1)'(1))]) begin
        idx = cand[PCT_W-1:0];
      end
    end
    return idx;
  endfunction

  function automatic logic [SHIFT_W-1:0] lux_shift(input logic [GAIN_W-1:0] gain,
                                                   input logic [INTEG_W-1:0] itc);
    logic [SHIFT_W-1:0] base;
    logic [INTEG_W-1:0] it;
    case (gain)
      2'd0:    base = 4'd4;
      2'd1:    base = 4'd3;
      2'd2:    base = 4'd1;
      default: base = 4'd0;
    endcase
    it = (itc > INTEG_MAX) ? INTEG_MAX : itc;
    return base + 4'd5 - SHIFT_W'(it);
  endfunction

endpackage

// File: src/lsa_if.sv
interface lsa_in_if;
  logic                           valid;
  logic                           ready;
  logic [lsa_pkg::RAW_W-1:0]      raw_count;
  logic                           read_failed;

  modport source (output valid, output raw_count, output read_failed, input ready);
  modport sink (input valid, input raw_count, input read_failed, output ready);
endinterface

interface lsa_out_if;
  logic                           valid;
  logic                           ready;
  logic                           lux_valid;
  logic [lsa_pkg::LUX_W-1:0]      filtered_lux;
  logic [lsa_pkg::PCT_W-1:0]      brightness_pct;
  logic                           range_changed;
  logic [lsa_pkg::GAIN_W-1:0]     gain_code;

  modport source (output valid, output lux_valid, output filtered_lux,
                  output brightness_pct, output range_changed, output gain_code,
                  input ready);
  modport sink (input valid, input lux_valid, input filtered_lux,
                input brightness_pct, input range_changed, input gain_code,
                output ready);
endinterface

// File: src/light_sensor_autorange_ema.sv
// Ambient light auto-range front end with a 0.85/0.15 moving average. One sample item is
// accepted every clock cycle unless backpressure stalls the input, and its result item
// passes through the first register stage (gain, average and lux) and then the output
// register (the backlight percentage lookup). The average recurrence, including the divide
// by 100, is combinational, which is what lets samples arrive back to back. Backpressure
// on the result side stalls both stages; a new sample is still taken while a result waits,
// as long as the middle stage is free. Configuration writes take effect on the next edge.
`include "light_sensor_autorange_ema_macros.svh"

module light_sensor_autorange_ema (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [lsa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lsa_pkg::CFG_DATA_W-1:0]    cfg_data,
  lsa_in_if.sink                            sample,
  lsa_out_if.source                         result
);

  logic [lsa_pkg::INTEG_W-1:0] integration_code;
  logic [lsa_pkg::RAW_W-1:0]   high_threshold;
  logic [lsa_pkg::RAW_W-1:0]   low_threshold;

  logic [lsa_pkg::GAIN_W-1:0]  gain_level, gain_level_next;
  logic                        skip_pending, skip_pending_next;
  logic [lsa_pkg::EMA_W-1:0]   ema_value, ema_value_next;
  logic                        ema_seeded, ema_seeded_next;

  logic                        b_valid;
  logic                        b_lux_valid;
  logic                        b_range_changed;
  logic [lsa_pkg::GAIN_W-1:0]  b_gain_code;
  logic [lsa_pkg::LUX_W-1:0]   b_filtered_lux;
  logic                        b_ready;
  logic                        in_fire;

  logic                        hit_high, hit_low, step_down, step_up, changed, keep;
  logic [lsa_pkg::SHIFT_W-1:0] shift;
  logic [lsa_pkg::LUX_W-1:0]   lux;
  logic [lsa_pkg::EMA_W-1:0]   lux_fix;

  logic [lsa_pkg::SUM_W-1:0]   ema_w, lux_w, sum;
  logic [lsa_pkg::X_W-1:0]     quarter;
  logic [lsa_pkg::XH_W-1:0]    x_hi;
  logic [lsa_pkg::CHUNK_W-1:0] x_lo;
  logic [lsa_pkg::S2_W-1:0]    fold;
  logic [lsa_pkg::PROD_W-1:0]  rec_prod;
  logic [lsa_pkg::QH_W-1:0]    q_hi;
  logic [lsa_pkg::QL_W-1:0]    q_lo;
  logic [lsa_pkg::EMA_W-1:0]   ema_div;

  assign b_ready      = !result.valid || result.ready;
  assign sample.ready = !b_valid || b_ready;
  assign in_fire      = sample.valid && sample.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      integration_code <= lsa_pkg::INTEG_RESET;
      high_threshold   <= lsa_pkg::HIGH_RESET;
      low_threshold    <= lsa_pkg::LOW_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lsa_pkg::REG_INTEGRATION:    integration_code <= cfg_data[lsa_pkg::INTEG_W-1:0];
        lsa_pkg::REG_HIGH_THRESHOLD: high_threshold   <= cfg_data[lsa_pkg::RAW_W-1:0];
        lsa_pkg::REG_LOW_THRESHOLD:  low_threshold    <= cfg_data[lsa_pkg::RAW_W-1:0];
        default: ;
      endcase
    end
  end

  // divide by 100 with round half up: quarter the sum, then split x/25 into
  // 2^20-sized chunks, since 2^20 leaves remainder 1 modulo 25
  always_comb begin
    ema_w    = lsa_pkg::SUM_W'(ema_value);
    lux_w    = lsa_pkg::SUM_W'(lux_fix);
    sum      = (ema_w << 6) + (ema_w << 4) + (ema_w << 2) + ema_w
             + (lux_w << 4) - lux_w + lsa_pkg::ROUND_HALF;
    quarter  = sum[lsa_pkg::SUM_W-1:2];
    x_hi     = quarter[lsa_pkg::X_W-1:lsa_pkg::CHUNK_W];
    x_lo     = quarter[lsa_pkg::CHUNK_W-1:0];
    fold     = lsa_pkg::S2_W'(x_hi) + lsa_pkg::S2_W'(x_lo);
    rec_prod = lsa_pkg::PROD_W'(fold) * lsa_pkg::PROD_W'(lsa_pkg::REC_M);
    q_lo     = rec_prod[lsa_pkg::PROD_W-1:lsa_pkg::REC_K];
    q_hi     = lsa_pkg::QH_W'(x_hi) * lsa_pkg::QH_W'(lsa_pkg::CHUNK_Q);
    ema_div  = lsa_pkg::EMA_W'(q_hi + lsa_pkg::QH_W'(q_lo));
  end

  always_comb begin
    hit_high  = sample.raw_count >= high_threshold;
    hit_low   = sample.raw_count <= low_threshold;
    step_down = !skip_pending && hit_high && (gain_level != lsa_pkg::GAIN_MIN);
    step_up   = !skip_pending && !hit_high && hit_low && (gain_level != lsa_pkg::GAIN_MAX);
    changed   = !sample.read_failed && (step_down || step_up);
    keep      = !sample.read_failed && !skip_pending && !changed;

    shift   = lsa_pkg::lux_shift(gain_level, integration_code);
    lux     = lsa_pkg::LUX_W'(sample.raw_count) << shift;
    lux_fix = {lux, {lsa_pkg::EMA_FRACTION_BITS{1'b0}}};

    gain_level_next = gain_level;
    if (!sample.read_failed && step_down) begin
      gain_level_next = gain_level - 2'd1;
    end else if (!sample.read_failed && step_up) begin
      gain_level_next = gain_level + 2'd1;
    end
    skip_pending_next = skip_pending && sample.read_failed;

    ema_value_next  = ema_value;
    ema_seeded_next = ema_seeded;
    if (keep) begin
      ema_value_next  = ema_seeded ? ema_div : lux_fix;
      ema_seeded_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_level   <= lsa_pkg::GAIN_RESET;
      skip_pending <= 1'b1;
      ema_value    <= '0;
      ema_seeded   <= 1'b0;
    end else if (in_fire) begin
      gain_level   <= gain_level_next;
      skip_pending <= skip_pending_next;
      ema_value    <= ema_value_next;
      ema_seeded   <= ema_seeded_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (sample.ready) begin
      b_valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      b_lux_valid     <= keep;
      b_range_changed <= changed;
      b_gain_code     <= gain_level_next;
      b_filtered_lux  <= ema_value_next[lsa_pkg::EMA_W-1:lsa_pkg::EMA_FRACTION_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (b_ready) begin
      result.valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b_valid && b_ready) begin
      result.lux_valid      <= b_lux_valid;
      result.range_changed  <= b_range_changed;
      result.gain_code      <= b_gain_code;
      result.filtered_lux   <= b_filtered_lux;
      result.brightness_pct <= lsa_pkg::PCT_MIN + lsa_pkg::bright_count(b_filtered_lux);
    end
  end

  `LSAE_ASSERT_NEXT(a_ema_hold, !in_fire, $stable(ema_value), "average moved without an item")
  `LSAE_ASSERT(a_valid_seeded, b_valid && b_lux_valid |-> ema_seeded, "lux valid before seeding")
  `LSAE_ASSERT_NEXT(a_gain_step, 1'b1, (gain_level == $past(gain_level)) || ({1'b0, gain_level} == {1'b0, $past(gain_level)} + 3'd1) || ({1'b0, $past(gain_level)} == {1'b0, gain_level} + 3'd1), "gain moved by more than one level")
  `LSAE_ASSERT_NEXT(a_stage_hold, b_valid && !b_ready, b_valid && $stable(b_filtered_lux), "stalled item lost")

endmodule

// File: test/light_sensor_autorange_ema_checker.sv
`timescale 1ns / 100ps

module light_sensor_autorange_ema_checker
  import lsa_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  lsa_in_if                     sample,
  lsa_out_if                    result,
  output int                    failures,
  output int                    pending,
  output int                    lux_updates,
  output int                    gain_moves
);

  typedef struct packed {
    logic                lux_valid;
    logic [LUX_W-1:0]    filtered_lux;
    logic [PCT_W-1:0]    brightness_pct;
    logic                range_changed;
    logic [GAIN_W-1:0]   gain_code;
  } lux_reading_t;

  localparam int unsigned SHIFT_OFFSET = 5;
  localparam int unsigned GAIN_SHIFT [0:3] = '{4, 3, 1, 0};

  localparam int unsigned PCT_STEP_LUX [0:BRIGHT_STEPS-1] = '{
    27, 55, 86, 120, 158, 198, 243, 292, 345, 404,
    467, 537, 614, 697, 789, 889, 998, 1118, 1249,
    1392, 1548, 1719, 1907, 2111, 2336, 2581, 2849, 3142, 3463,
    3813, 4197, 4617, 5076, 5578, 6127, 6728, 7385, 8104,
    8890, 9749, 10690, 11719, 12844, 14074, 15421, 16893, 18504,
    20265, 22192, 24299, 26605, 29126, 31884, 34901, 38200, 41809,
    45757,
    50075, 54797, 59963, 65614, 71794, 78554, 85948, 94036, 102882,
    112558, 123142, 134718, 147380, 161230, 176378, 192948, 211072,
    230896, 252579,
    276296, 302237, 330612, 361649, 395596, 432727, 473342, 517766,
    566356, 619504, 677638, 741224, 810774, 886848, 970057, 1061071,
    1160622, 1269510, 1388612
  };

  logic [INTEG_W-1:0] integ_sel;
  logic [RAW_W-1:0]   high_th;
  logic [RAW_W-1:0]   low_th;
  logic [GAIN_W-1:0]  gain_lvl;
  logic               drop_armed;
  logic [63:0]        ema_fix;
  logic               seeded;
  lux_reading_t       readings_due [$];

  function automatic lux_reading_t predict_reading(input logic [RAW_W-1:0] raw,
                                                   input logic fail);
    lux_reading_t       r;
    logic [63:0]        lux_fix;
    logic [63:0]        lux_int;
    int unsigned        shift;
    logic [INTEG_W-1:0] it;
    r = '0;
    if (!fail) begin
      if (!drop_armed) begin
        if (raw >= high_th) begin
          if (gain_lvl != GAIN_MIN) begin
            gain_lvl--;
            r.range_changed = 1'b1;
          end
        end else if (raw <= low_th) begin
          if (gain_lvl != GAIN_MAX) begin
            gain_lvl++;
            r.range_changed = 1'b1;
          end
        end
      end
      if (drop_armed || r.range_changed) begin
        drop_armed = 1'b0;
      end else begin
        it = (integ_sel > INTEG_MAX) ? INTEG_MAX : integ_sel;
        shift = GAIN_SHIFT[gain_lvl] + SHIFT_OFFSET - 32'(it);
        lux_fix = (64'(raw) << shift) << EMA_FRACTION_BITS;
        if (!seeded) begin
          ema_fix = lux_fix;
          seeded = 1'b1;
        end else begin
          ema_fix = (64'd85 * ema_fix + 64'd15 * lux_fix + 64'd50) / 64'd100;
        end
        r.lux_valid = 1'b1;
      end
    end
    lux_int = ema_fix >> EMA_FRACTION_BITS;
    r.filtered_lux = LUX_W'(lux_int);
    r.brightness_pct = PCT_MIN;
    for (int i = 0; i < BRIGHT_STEPS; i++) begin
      if (lux_int >= 64'(PCT_STEP_LUX[i])) r.brightness_pct++;
    end
    r.gain_code = gain_lvl;
    return r;
  endfunction

  function automatic void check_field(input string field, input longint unsigned want,
                                      input longint unsigned got);
    if (want != got) begin
      failures++;
      $display("%0t mismatch on %s: expected %0d, got %0d", $time, field, want, got);
    end
  endfunction

  always @(posedge clk) begin
    lux_reading_t want;
    if (rst) begin
      integ_sel = INTEG_RESET;
      high_th = HIGH_RESET;
      low_th = LOW_RESET;
      gain_lvl = GAIN_RESET;
      drop_armed = 1'b1;
      ema_fix = '0;
      seeded = 1'b0;
      readings_due.delete();
      failures = 0;
      lux_updates = 0;
      gain_moves = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_INTEGRATION:    integ_sel = cfg_data[INTEG_W-1:0];
          REG_HIGH_THRESHOLD: high_th = cfg_data[RAW_W-1:0];
          REG_LOW_THRESHOLD:  low_th = cfg_data[RAW_W-1:0];
          default: ;
        endcase
      end
      if (sample.valid && sample.ready) begin
        want = predict_reading(sample.raw_count, sample.read_failed);
        if (want.lux_valid) lux_updates++;
        if (want.range_changed) gain_moves++;
        readings_due.push_back(want);
      end
      if (result.valid && result.ready) begin
        if (readings_due.size() == 0) begin
          failures++;
          $display("%0t unexpected result item: expected none, got lux %0d gain %0d",
                   $time, result.filtered_lux, result.gain_code);
        end else begin
          want = readings_due.pop_front();
          check_field("lux_valid", 64'(want.lux_valid), 64'(result.lux_valid));
          check_field("filtered_lux", 64'(want.filtered_lux), 64'(result.filtered_lux));
          check_field("brightness_pct", 64'(want.brightness_pct),
                      64'(result.brightness_pct));
          check_field("range_changed", 64'(want.range_changed),
                      64'(result.range_changed));
          check_field("gain_code", 64'(want.gain_code), 64'(result.gain_code));
        end
      end
    end
    pending = readings_due.size();
  end

endmodule

// File: test/light_sensor_autorange_ema_tb.sv
`timescale 1ns / 100ps

module light_sensor_autorange_ema_tb;
  import lsa_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 4;
  localparam int LONG_HOLD     = 300;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef enum int {ZONE_LOW, ZONE_HIGH, ZONE_MID, ZONE_ANY} raw_zone_t;
  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_TOGGLE} rx_mode_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  lsa_in_if  sample_ch ();
  lsa_out_if result_ch ();

  int failures;
  int pending;
  int lux_updates;
  int gain_moves;
  int items_sent;
  int settings_used;
  int cycle_count;
  int burst_left;
  int hold_requests;
  int holds_done;
  logic [RAW_W-1:0] cur_high;
  logic [RAW_W-1:0] cur_low;

  light_sensor_autorange_ema uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sample    (sample_ch),
    .result    (result_ch)
  );

  light_sensor_autorange_ema_checker lux_checker (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .sample      (sample_ch),
    .result      (result_ch),
    .failures    (failures),
    .pending     (pending),
    .lux_updates (lux_updates),
    .gain_moves  (gain_moves)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles with %0d items outstanding", cycle_count, pending);
    $display("status: fail");
    $finish;
  end

  // result side: random stall modes, plus a long hold when requested
  initial begin
    rx_mode_t mode;
    int       mode_left;
    int       hold_left;
    result_ch.ready = 1'b0;
    mode = RX_OPEN;
    mode_left = 0;
    hold_left = 0;
    holds_done = 0;
    forever begin
      @(negedge clk);
      if (holds_done != hold_requests) begin
        holds_done++;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = rx_mode_t'($urandom_range(3, 0));
          mode_left = $urandom_range(80, 10);
        end
        mode_left--;
        case (mode)
          RX_OPEN:   result_ch.ready <= 1'b1;
          RX_COIN:   result_ch.ready <= 1'($urandom_range(1, 0));
          RX_SPARSE: result_ch.ready <= ($urandom_range(3, 0) == 0);
          default:   result_ch.ready <= (mode_left % 2 == 0);
        endcase
      end
    end
  end

  task automatic offer_sample(input logic [RAW_W-1:0] raw, input logic fail);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(24, 1);
      gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(8, 1);
      if (gap > 0) begin
        sample_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    sample_ch.valid <= 1'b1;
    sample_ch.raw_count <= raw;
    sample_ch.read_failed <= fail;
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
    @(negedge clk);
    burst_left--;
    items_sent++;
  endtask

  task automatic settle();
    sample_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
  endtask

  task automatic apply_setting(input logic [INTEG_W-1:0] integ,
                               input logic [RAW_W-1:0] high,
                               input logic [RAW_W-1:0] low);
    settle();
    write_reg(REG_INTEGRATION, CFG_DATA_W'(integ));
    write_reg(REG_HIGH_THRESHOLD, high);
    write_reg(REG_LOW_THRESHOLD, low);
    write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
    cfg_we <= 1'b0;
    cur_high = high;
    cur_low = low;
    settings_used++;
  endtask

  // runs of samples from one zone so the gain walks and the average settles
  task automatic random_run(input int count);
    int               done;
    int               run_len;
    raw_zone_t        zone;
    logic [RAW_W-1:0] raw;
    done = 0;
    while (done < count) begin
      zone = raw_zone_t'($urandom_range(3, 0));
      run_len = $urandom_range(10, 1);
      repeat (run_len) begin
        case (zone)
          ZONE_LOW:  raw = RAW_W'($urandom_range(cur_low, 0));
          ZONE_HIGH: raw = RAW_W'($urandom_range(65535, cur_high));
          ZONE_MID:  raw = (cur_high > cur_low + 1) ?
                           RAW_W'($urandom_range(cur_high - 1, cur_low + 1)) :
                           RAW_W'($urandom);
          default:   raw = RAW_W'($urandom);
        endcase
        offer_sample(raw, $urandom_range(11, 0) == 0);
        done++;
      end
    end
  endtask

  initial begin
    logic [RAW_W-1:0] high;
    logic [RAW_W-1:0] low;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_INTEGRATION;
    cfg_data = '0;
    sample_ch.valid = 1'b0;
    sample_ch.raw_count = '0;
    sample_ch.read_failed = 1'b0;
    hold_requests = 0;
    burst_left = 0;
    items_sent = 0;
    settings_used = 0;
    cur_high = HIGH_RESET;
    cur_low = LOW_RESET;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    offer_sample(16'hFFFF, 1'b1);
    offer_sample(16'd500, 1'b0);
    offer_sample(16'd500, 1'b0);
    offer_sample(16'd100, 1'b0);
    offer_sample(16'd0, 1'b0);
    offer_sample(16'd0, 1'b0);
    offer_sample(16'd65520, 1'b0);
    offer_sample(16'hFFFF, 1'b0);
    offer_sample(16'hFFFF, 1'b0);
    offer_sample(16'hFFFF, 1'b0);
    offer_sample(16'hFFFF, 1'b0);
    offer_sample(16'd65519, 1'b0);
    offer_sample(16'd101, 1'b0);
    offer_sample(16'd0, 1'b1);

    apply_setting(3'd7, 16'd0, 16'hFFFF);
    offer_sample(16'd0, 1'b0);
    offer_sample(16'hFFFF, 1'b0);
    apply_setting(3'd0, 16'hFFFF, 16'hFFFF);
    offer_sample(16'd30000, 1'b0);
    offer_sample(16'd30000, 1'b0);
    offer_sample(16'hFFFF, 1'b0);

    apply_setting(3'd7, 16'd0, 16'hFFFF);
    random_run(60);
    apply_setting(3'd0, 16'hFFFF, 16'd0);
    random_run(120);
    apply_setting(3'd5, 16'd40000, 16'd2000);
    hold_requests++;
    random_run(120);
    apply_setting(3'd6, HIGH_RESET, LOW_RESET);
    random_run(120);
    repeat (3) begin
      low = RAW_W'($urandom_range(30000, 0));
      high = RAW_W'($urandom_range(65535, low));
      apply_setting(INTEG_W'($urandom_range(7, 0)), high, low);
      random_run(120);
    end
    settle();

    $display("covered %0d sample items over %0d register settings",
             items_sent, settings_used + 1);
    $display("%0d items updated the average, %0d moved the gain", lux_updates, gain_moves);
    if (failures == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
